[sv/hsd_pkg.sv]
// shared constants and types of the 3-d heat stencil step
`default_nettype none

package hsd_pkg;

   localparam int MAX_DIM_DEF     = 64;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam int COEFF_W     = 16;
   localparam int FRAC_BITS   = 16;
   localparam int ROUND_HALF  = 1 << (FRAC_BITS - 1);
   localparam int SUM_W       = 48;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int PLANES      = 3;
   localparam int PLANE_W     = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_COEFF_X   = 3'd0,
      REG_COEFF_Y   = 3'd1,
      REG_COEFF_Z   = 3'd2,
      REG_TIME_STEP = 3'd3,
      REG_LAST_X    = 3'd4,
      REG_LAST_Y    = 3'd5,
      REG_LAST_Z    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [COEFF_W-1:0] coeff_x;
      logic [COEFF_W-1:0] coeff_y;
      logic [COEFF_W-1:0] coeff_z;
      logic [COEFF_W-1:0] time_step;
   } coeff_type;

   // classification of one grid point, made by the front part
   typedef struct packed {
      logic               interior;
      logic               final_pt;
      logic [PLANE_W-1:0] plane;
   } class_type;

endpackage

`default_nettype wire

[sv/hsd_req_if.sv]
// request channel of the heat stencil step: one grid point per transfer
`default_nettype none

interface hsd_req_if #(
   parameter int VALUE_WIDTH = hsd_pkg::VALUE_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] sample;
   logic signed [VALUE_WIDTH-1:0] force_req;

   modport source (output valid, output sample, output force_req, input ready);
   modport sink   (input valid, input sample, input force_req, output ready);
endinterface

`default_nettype wire

[sv/hsd_rsp_if.sv]
// response channel of the heat stencil step: one updated interior point per transfer
`default_nettype none

interface hsd_rsp_if #(
   parameter int MAX_DIM     = hsd_pkg::MAX_DIM_DEF,
   parameter int VALUE_WIDTH = hsd_pkg::VALUE_WIDTH_DEF
);
   localparam int DIM_W = $clog2(MAX_DIM);

   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] new_value;
   logic [DIM_W-1:0]              x_index;
   logic [DIM_W-1:0]              y_index;
   logic [DIM_W-1:0]              z_index;
   logic [hsd_pkg::SUM_W-1:0]     variation_sum;
   logic                          final_point;

   modport source (output valid, output new_value, output x_index, output y_index,
                   output z_index, output variation_sum, output final_point, input ready);
   modport sink   (input valid, input new_value, input x_index, input y_index,
                   input z_index, input variation_sum, input final_point, output ready);
endinterface

`default_nettype wire

[sv/heat_stencil_3d_step.sv]
// top level of the 3-d heat stencil step: registers, front, queue and back
`default_nettype none

// channel   direction  handshake        payload
// req_bus   in         valid / ready    sample, force_req
// rsp_bus   out        valid / ready    new_value, x/y/z_index, variation_sum, final_point
// csr_*     in         csr_we           csr_index, csr_wdata (no read-back)
//
// one grid point per cycle is taken while the queue has room; an interior point's result
// leaves after its neighbor one plane later arrives, passing the queue, memory read,
// stencil adds, multiply, two adder levels, round and saturate and the result register
// reset clears position, running sum, queue and pipeline; plane memories are not
// cleared, so stencil reads of never written entries return undefined data
// a stalled result holds the back pipeline; the front keeps taking points until
// the queue between them is full

module heat_stencil_3d_step #(
   parameter int MAX_DIM     = hsd_pkg::MAX_DIM_DEF,
   parameter int VALUE_WIDTH = hsd_pkg::VALUE_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   hsd_req_if.sink                         req_bus,
   hsd_rsp_if.source                       rsp_bus,
   input  logic                            csr_we,
   input  logic [hsd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hsd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import hsd_pkg::*;

   localparam int DIM_W   = $clog2(MAX_DIM);
   localparam int ENTRY_W = 2 * VALUE_WIDTH + 3 * DIM_W + $bits(class_type);

   // configuration registers
   coeff_type        coeff_ff;
   logic [DIM_W-1:0] last_x_ff, last_y_ff, last_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff  <= '0;
         last_x_ff <= DIM_W'(MAX_DIM - 1);
         last_y_ff <= DIM_W'(MAX_DIM - 1);
         last_z_ff <= DIM_W'(MAX_DIM - 1);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_COEFF_X:   coeff_ff.coeff_x   <= csr_wdata[COEFF_W-1:0];
            REG_COEFF_Y:   coeff_ff.coeff_y   <= csr_wdata[COEFF_W-1:0];
            REG_COEFF_Z:   coeff_ff.coeff_z   <= csr_wdata[COEFF_W-1:0];
            REG_TIME_STEP: coeff_ff.time_step <= csr_wdata[COEFF_W-1:0];
            REG_LAST_X:    last_x_ff          <= csr_wdata[DIM_W-1:0];
            REG_LAST_Y:    last_y_ff          <= csr_wdata[DIM_W-1:0];
            REG_LAST_Z:    last_z_ff          <= csr_wdata[DIM_W-1:0];
            default: ; // unused index, write dropped
         endcase
      end
   end

   // front to queue to back
   logic               q_push, q_full, q_pop, q_valid;
   logic [ENTRY_W-1:0] q_push_data, q_pop_data;

   hsd_front #(
      .DIM_W       (DIM_W),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .last_x  (last_x_ff),
      .last_y  (last_y_ff),
      .last_z  (last_z_ff),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_data  (q_push_data)
   );

   hsd_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_pop_data)
   );

   hsd_back #(
      .DIM_W       (DIM_W),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .coeff   (coeff_ff),
      .q_valid (q_valid),
      .q_data  (q_pop_data),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

`ifndef SYNTHESIS
   // no stale result survives reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("result pending right after reset");

   // only interior points produce results
   a_interior_only: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.x_index != '0) && (rsp_bus.x_index < last_x_ff) &&
                        (rsp_bus.y_index != '0) && (rsp_bus.y_index < last_y_ff))
      else $error("result for a border point");

   // the last point of a sweep sits at the far interior corner
   a_final_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.final_point |->
         (rsp_bus.x_index == last_x_ff - DIM_W'(1)) &&
         (rsp_bus.y_index == last_y_ff - DIM_W'(1)) &&
         (rsp_bus.z_index == last_z_ff - DIM_W'(1)))
      else $error("final point away from the interior corner");
`endif

endmodule

`default_nettype wire

[sv/hsd_front.sv]
// front part: raster position tracking and point classification
`default_nettype none

module hsd_front #(
   parameter int DIM_W       = 6,
   parameter int VALUE_WIDTH = hsd_pkg::VALUE_WIDTH_DEF,
   localparam int ENTRY_W    = 2 * VALUE_WIDTH + 3 * DIM_W + $bits(hsd_pkg::class_type)
) (
   input  logic               clock,
   input  logic               reset,
   hsd_req_if.sink            req_bus,
   input  logic [DIM_W-1:0]   last_x,
   input  logic [DIM_W-1:0]   last_y,
   input  logic [DIM_W-1:0]   last_z,
   input  logic               q_full,
   output logic               q_push,
   output logic [ENTRY_W-1:0] q_data
);
   import hsd_pkg::*;

   logic [DIM_W-1:0]   x_ff, y_ff, z_ff;
   logic [DIM_W-1:0]   x_in, y_in, z_in;
   logic [PLANE_W-1:0] plane_ff, plane_in;
   class_type          cls;
   logic               accept;

   assign req_bus.ready = !q_full;
   assign accept        = req_bus.valid && !q_full;

   always_comb begin
      cls.interior = (z_ff >= DIM_W'(2)) && (y_ff != '0) && (y_ff < last_y) &&
                     (x_ff != '0) && (x_ff < last_x);
      cls.final_pt = (x_ff == last_x - DIM_W'(1)) && (y_ff == last_y - DIM_W'(1)) &&
                     (z_ff == last_z);
      cls.plane    = plane_ff;
   end

   // raster advance, x fastest; plane follows z modulo three
   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      plane_in = plane_ff;
      if (x_ff >= last_x) begin
         x_in = '0;
         if (y_ff >= last_y) begin
            y_in = '0;
            if (z_ff >= last_z) begin
               z_in     = '0;
               plane_in = '0;
            end else begin
               z_in     = z_ff + DIM_W'(1);
               plane_in = (plane_ff == PLANE_W'(PLANES - 1)) ? '0 : plane_ff + PLANE_W'(1);
            end
         end else begin
            y_in = y_ff + DIM_W'(1);
         end
      end else begin
         x_in = x_ff + DIM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff     <= '0;
         y_ff     <= '0;
         z_ff     <= '0;
         plane_ff <= '0;
      end else if (accept) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= z_in;
         plane_ff <= plane_in;
      end
   end

   // the updated point sits one plane behind the arriving sample
   assign q_push = accept;
   assign q_data = {req_bus.sample, req_bus.force_req, x_ff, y_ff, z_ff - DIM_W'(1), cls};

endmodule

`default_nettype wire

[sv/hsd_queue.sv]
// short first-in first-out queue between front and back parts
`default_nettype none

module hsd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = hsd_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

[sv/hsd_back.sv]
// back part: plane stores, stencil arithmetic pipeline and result register
`default_nettype none

module hsd_back #(
   parameter int DIM_W       = 6,
   parameter int VALUE_WIDTH = hsd_pkg::VALUE_WIDTH_DEF,
   localparam int ENTRY_W    = 2 * VALUE_WIDTH + 3 * DIM_W + $bits(hsd_pkg::class_type)
) (
   input  logic               clock,
   input  logic               reset,
   input  hsd_pkg::coeff_type coeff,
   input  logic               q_valid,
   input  logic [ENTRY_W-1:0] q_data,
   output logic               q_pop,
   hsd_rsp_if.source          rsp_bus
);
   import hsd_pkg::*;

   localparam int VW      = VALUE_WIDTH;
   localparam int CLS_W   = $bits(class_type);
   localparam int D_W     = VW + 2;
   localparam int PX_W    = D_W + COEFF_W + 1;
   localparam int PF_W    = VW + COEFF_W + 1;
   localparam int ACC_W   = PX_W + 2;
   localparam int CH_W    = ACC_W - FRAC_BITS;
   localparam int N_W     = CH_W + 1;
   localparam int EXT_W   = ((CH_W > SUM_W) ? CH_W : SUM_W) + 1;
   localparam int NUM_ST  = 6;
   localparam int SA_W    = PLANE_W + 2 * DIM_W;
   localparam int S_DEPTH = PLANES << (2 * DIM_W);
   localparam int FA_W    = 1 + 2 * DIM_W;
   localparam int F_DEPTH = 2 << (2 * DIM_W);
   localparam int NUM_TAP = 6;
   localparam int TAP_C   = 0;
   localparam int TAP_E   = 1;
   localparam int TAP_W   = 2;
   localparam int TAP_N   = 3;
   localparam int TAP_S   = 4;
   localparam int TAP_B   = 5;

   localparam logic signed [N_W-1:0] NV_MAX = N_W'({1'b0, {(VW - 1){1'b1}}});
   localparam logic signed [N_W-1:0] NV_MIN = -NV_MAX - N_W'(1);
   localparam logic [EXT_W-1:0]      SUM_MAX = EXT_W'({SUM_W{1'b1}});

   typedef struct packed {
      logic [DIM_W-1:0] x;
      logic [DIM_W-1:0] y;
      logic [DIM_W-1:0] z;
      logic             final_pt;
   } tag_type;

   // queue head
   class_type              h_cls;
   logic [DIM_W-1:0]       h_x, h_y, h_z;
   logic signed [VW-1:0]   h_sample, h_force;
   logic [PLANE_W-1:0]     pc, pb;
   logic                   advance;
   logic                   pop_live;

   assign h_cls    = q_data[CLS_W-1:0];
   assign h_z      = q_data[CLS_W +: DIM_W];
   assign h_y      = q_data[CLS_W + DIM_W +: DIM_W];
   assign h_x      = q_data[CLS_W + 2 * DIM_W +: DIM_W];
   assign h_force  = $signed(q_data[CLS_W + 3 * DIM_W +: VW]);
   assign h_sample = $signed(q_data[CLS_W + 3 * DIM_W + VW +: VW]);

   logic out_valid_ff;
   assign advance  = !out_valid_ff || rsp_bus.ready;
   assign q_pop    = advance && q_valid;
   assign pop_live = q_pop && h_cls.interior;

   // center plane and back plane, one and two behind the plane being written
   always_comb begin
      unique case (h_cls.plane)
         PLANE_W'(0): begin pc = PLANE_W'(2); pb = PLANE_W'(1); end
         PLANE_W'(1): begin pc = PLANE_W'(0); pb = PLANE_W'(2); end
         PLANE_W'(2): begin pc = PLANE_W'(1); pb = PLANE_W'(0); end
         default:     begin pc = PLANE_W'(0); pb = PLANE_W'(0); end
      endcase
   end

   logic [SA_W-1:0]      wr_addr;
   logic [SA_W-1:0]      rd_addr [NUM_TAP];
   logic signed [VW-1:0] tap     [NUM_TAP];

   always_comb begin
      wr_addr        = {h_cls.plane, h_y, h_x};
      rd_addr[TAP_C] = {pc, h_y, h_x};
      rd_addr[TAP_E] = {pc, h_y, h_x + DIM_W'(1)};
      rd_addr[TAP_W] = {pc, h_y, h_x - DIM_W'(1)};
      rd_addr[TAP_N] = {pc, h_y + DIM_W'(1), h_x};
      rd_addr[TAP_S] = {pc, h_y - DIM_W'(1), h_x};
      rd_addr[TAP_B] = {pb, h_y, h_x};
   end

   // three identical copies of the sample planes, two read ports each
   for (genvar k = 0; k < NUM_TAP / 2; k++) begin : g_window
      logic signed [VW-1:0] win_mem [S_DEPTH];
      logic signed [VW-1:0] rd0_ff, rd1_ff;

      always_ff @(posedge clock) begin
         if (q_pop) begin
            win_mem[wr_addr] <= h_sample;
         end
         if (advance) begin
            rd0_ff <= win_mem[rd_addr[2 * k]];
            rd1_ff <= win_mem[rd_addr[2 * k + 1]];
         end
      end

      assign tap[2 * k]     = rd0_ff;
      assign tap[2 * k + 1] = rd1_ff;
   end

   // force planes, indexed by the low bit of z
   logic signed [VW-1:0] force_mem [F_DEPTH];
   logic signed [VW-1:0] f_rd_ff;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         force_mem[{~h_z[0], h_y, h_x}] <= h_force;
      end
      if (advance) begin
         f_rd_ff <= force_mem[FA_W'({h_z[0], h_y, h_x})];
      end
   end

   // pipeline payload
   logic signed [VW-1:0]    s1_sample_ff;
   tag_type                 tag_ff [NUM_ST];
   tag_type                 tag_in;
   logic signed [D_W-1:0]   dxx_ff, dyy_ff, dzz_ff, dxx_in, dyy_in, dzz_in;
   logic signed [VW-1:0]    c2_ff, c3_ff, c4_ff, c5_ff, f2_ff;
   logic signed [PX_W-1:0]  px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic signed [PF_W-1:0]  pf_ff, pf_in;
   logic signed [ACC_W-1:0] sum01_ff, sum23_ff, sum01_in, sum23_in, acc_ff, acc_in;
   logic signed [CH_W-1:0]  change;
   logic signed [N_W-1:0]   nv_wide;
   logic signed [VW-1:0]    nv_ff, nv_in;
   logic [CH_W-1:0]         mag_ff, mag_in;
   logic [NUM_ST-1:0]       st_valid_ff;
   logic [SUM_W-1:0]        total_ff, sum_in;
   logic [EXT_W-1:0]        sum_ext;

   assign tag_in = '{x: h_x, y: h_y, z: h_z, final_pt: h_cls.final_pt};

   always_comb begin
      dxx_in   = D_W'(tap[TAP_E]) + D_W'(tap[TAP_W]) - (D_W'(tap[TAP_C]) <<< 1);
      dyy_in   = D_W'(tap[TAP_N]) + D_W'(tap[TAP_S]) - (D_W'(tap[TAP_C]) <<< 1);
      dzz_in   = D_W'(s1_sample_ff) + D_W'(tap[TAP_B]) - (D_W'(tap[TAP_C]) <<< 1);

      px_in    = $signed({1'b0, coeff.coeff_x}) * dxx_ff;
      py_in    = $signed({1'b0, coeff.coeff_y}) * dyy_ff;
      pz_in    = $signed({1'b0, coeff.coeff_z}) * dzz_ff;
      pf_in    = $signed({1'b0, coeff.time_step}) * f2_ff;

      sum01_in = ACC_W'(px_ff) + ACC_W'(py_ff);
      sum23_in = ACC_W'(pz_ff) + ACC_W'(pf_ff);
      acc_in   = sum01_ff + sum23_ff + ACC_W'(ROUND_HALF);

      // floor of the biased sum gives round to nearest, ties upward
      change   = $signed(acc_ff[ACC_W-1:FRAC_BITS]);
      nv_wide  = N_W'(c5_ff) + N_W'(change);
      if (nv_wide > NV_MAX) begin
         nv_in = $signed({1'b0, {(VW - 1){1'b1}}});
      end else if (nv_wide < NV_MIN) begin
         nv_in = $signed({1'b1, {(VW - 1){1'b0}}});
      end else begin
         nv_in = nv_wide[VW-1:0];
      end
      mag_in   = change[CH_W-1] ? CH_W'(-change) : CH_W'(change);

      sum_ext  = EXT_W'(total_ff) + EXT_W'(mag_ff);
      sum_in   = (sum_ext > SUM_MAX) ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sample_ff <= h_sample;
         tag_ff[0]    <= tag_in;
         for (int i = 1; i < NUM_ST; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
         dxx_ff   <= dxx_in;
         dyy_ff   <= dyy_in;
         dzz_ff   <= dzz_in;
         c2_ff    <= tap[TAP_C];
         f2_ff    <= f_rd_ff;
         px_ff    <= px_in;
         py_ff    <= py_in;
         pz_ff    <= pz_in;
         pf_ff    <= pf_in;
         c3_ff    <= c2_ff;
         sum01_ff <= sum01_in;
         sum23_ff <= sum23_in;
         c4_ff    <= c3_ff;
         acc_ff   <= acc_in;
         c5_ff    <= c4_ff;
         nv_ff    <= nv_in;
         mag_ff   <= mag_in;
         rsp_bus.new_value     <= nv_ff;
         rsp_bus.x_index       <= tag_ff[NUM_ST-1].x;
         rsp_bus.y_index       <= tag_ff[NUM_ST-1].y;
         rsp_bus.z_index       <= tag_ff[NUM_ST-1].z;
         rsp_bus.final_point   <= tag_ff[NUM_ST-1].final_pt;
         rsp_bus.variation_sum <= sum_in;
      end
   end

   // control and the running sum, which advances in result order
   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff  <= '0;
         out_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else if (advance) begin
         st_valid_ff  <= {st_valid_ff[NUM_ST-2:0], pop_live};
         out_valid_ff <= st_valid_ff[NUM_ST-1];
         if (st_valid_ff[NUM_ST-1]) begin
            total_ff <= tag_ff[NUM_ST-1].final_pt ? '0 : sum_in;
         end
      end
   end

   assign rsp_bus.valid = out_valid_ff;

endmodule

`default_nettype wire
